// ===== src/element_to_single_float_converter_assert.svh =====
// Assertion macros for the element to single float converter.
// Needs a clock and a synchronous active-low reset named i_clk and i_rst_n.
`ifndef ELEMENT_TO_SINGLE_FLOAT_CONVERTER_ASSERT_SVH
`define ELEMENT_TO_SINGLE_FLOAT_CONVERTER_ASSERT_SVH

// Implication checked at every clock edge outside reset.
`define ESF_ASSERT_IMP(label, lhs, rhs) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (lhs) |-> (rhs)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define ESF_ASSERT_NXT(label, lhs, rhs) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (lhs) |=> (rhs)) \
        else $error("assertion failed");

`endif

// ===== src/esf_pkg.sv =====
// Package for the element to single float converter: format codes and widths.
// No dependencies.
`default_nettype none
package esf_pkg;
    localparam int unsigned DataW = 32;
    localparam int unsigned FmtW  = 3;
    localparam int unsigned PipeDepth = 3;

    typedef enum logic [FmtW-1:0] {
        FMT_SINGLE = 3'd0,
        FMT_BF16   = 3'd1,
        FMT_HALF   = 3'd2,
        FMT_BYTE   = 3'd3,
        FMT_NIBBLE = 3'd4
    } t_fmt;

    typedef struct packed {
        logic [DataW-1:0] element_bits;
        logic             last_element;
    } t_in_req;

    typedef struct packed {
        logic [DataW-1:0] float_bits;
        logic             format_error;
        logic             last_out;
    } t_out_req;

    typedef struct packed {
        logic             valid;
        logic             stall;
    } t_stage_ctl;
endpackage
`default_nettype wire

// ===== src/esf_if.sv =====
// Valid/ready channel interfaces for the converter's input, output and config.
// Depends on esf_pkg.
`default_nettype none
interface esf_in_if;
    logic             valid;
    logic             ready;
    esf_pkg::t_in_req payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface esf_out_if;
    logic              valid;
    logic              ready;
    esf_pkg::t_out_req payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface esf_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [esf_pkg::FmtW-1:0]   data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== src/element_to_single_float_converter.sv =====
// Top level of the element to single float converter: a three-stage pipeline.
// Depends on esf_pkg, esf_if, esf_lzc and the assertion macro header.
//
//  Channel   Dir  Handshake     Contents
//  i_elem    in   valid/ready   element_bits, last_element
//  o_float   out  valid/ready   float_bits, format_error, last_out
//  i_cfg     in   valid/ready   source_format (3 bits)
//
// Every element passes through the stage 1, stage 2 and result registers, and
// a new element may enter in each cycle unless all stages are full and stalled.
// Reset clears the stage valid bits and sets the format to single precision.
// When the output is not taken the stages hold in place: a stage advances only
// when the stage after it is empty or moving, so nothing is lost or repeated.
`default_nettype none
`include "element_to_single_float_converter_assert.svh"
module element_to_single_float_converter (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    esf_in_if.sink    i_elem,
    esf_out_if.source o_float,
    esf_cfg_if.sink   i_cfg
);
    // The stage count is fixed by the datapath below.
    localparam int unsigned NStage = esf_pkg::PipeDepth;

    logic [esf_pkg::FmtW-1:0] r_fmt;
    logic [NStage-1:0]        r_vld;
    logic [NStage-1:0]        adv;

    // Stage 1 registers: decoded fields.
    logic [31:0] r1_bits;
    logic        r1_last;
    logic [esf_pkg::FmtW-1:0] r1_fmt;
    logic        r1_sign;
    logic [4:0]  r1_hexp;
    logic [9:0]  r1_hman;
    logic [7:0]  r1_bmag;   // byte magnitude, 128 shows as 8'h80

    // Stage 2 registers: normalised pieces.
    logic [31:0] r2_bits;
    logic        r2_last;
    logic [esf_pkg::FmtW-1:0] r2_fmt;
    logic        r2_sign;
    logic [4:0]  r2_hexp;
    logic [9:0]  r2_hman;
    logic [3:0]  r2_hsh;
    logic [7:0]  r2_bmag;
    logic [2:0]  r2_bmsb;

    esf_pkg::t_out_req r3_out;
    esf_pkg::t_stage_ctl ctl3;

    // Back-pressure: a stage register loads when it is empty or its request moves on.
    assign ctl3.valid = r_vld[NStage-1];
    assign ctl3.stall = r_vld[NStage-1] && !o_float.ready;
    always_comb begin
        adv[NStage-1] = !ctl3.stall;
        for (int s = NStage - 2; s >= 0; s--) begin
            adv[s] = !r_vld[s] || adv[s+1];
        end
    end

    assign i_elem.ready  = adv[0];
    assign i_cfg.ready   = 1'b1;
    assign o_float.valid = ctl3.valid;
    assign o_float.payload = r3_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt <= esf_pkg::FMT_SINGLE;
            r_vld <= '0;
        end else begin
            if (i_cfg.valid) begin
                r_fmt <= i_cfg.data;
            end
            if (adv[0]) r_vld[0] <= i_elem.valid;
            for (int s = 1; s < NStage; s++) begin
                if (adv[s]) r_vld[s] <= r_vld[s-1];
            end
        end
    end

    // Stage 1: split the fields and form the byte magnitude.
    logic [7:0] s0_byte;
    assign s0_byte = i_elem.payload.element_bits[7:0];
    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r1_bits <= i_elem.payload.element_bits;
            r1_last <= i_elem.payload.last_element;
            r1_fmt  <= r_fmt;
            r1_sign <= (r_fmt == esf_pkg::FMT_BYTE) ? s0_byte[7]
                                                    : i_elem.payload.element_bits[15];
            r1_hexp <= i_elem.payload.element_bits[14:10];
            r1_hman <= i_elem.payload.element_bits[9:0];
            r1_bmag <= s0_byte[7] ? 8'(~s0_byte + 8'd1) : s0_byte;
        end
    end

    // Stage 2: find the leading one for subnormal halves and for bytes.
    logic [3:0] s1_hsh;
    logic [2:0] s1_bmsb;
    esf_lzc u_lzc (.i_mant(r1_hman), .o_shift(s1_hsh));
    always_comb begin
        s1_bmsb = 3'd0;
        for (int k = 0; k < 8; k++) begin
            if (r1_bmag[k]) s1_bmsb = 3'(k);
        end
    end
    always_ff @(posedge i_clk) begin
        if (adv[1]) begin
            r2_bits <= r1_bits;
            r2_last <= r1_last;
            r2_fmt  <= r1_fmt;
            r2_sign <= r1_sign;
            r2_hexp <= r1_hexp;
            r2_hman <= r1_hman;
            r2_hsh  <= s1_hsh;
            r2_bmag <= r1_bmag;
            r2_bmsb <= s1_bmsb;
        end
    end

    // Stage 3: assemble the single-precision word.
    logic [31:0] s2_half, s2_byte, s2_res;
    logic [10:0] s2_norm;
    logic [22:0] s2_bfrac;
    logic        s2_err;
    always_comb begin
        s2_norm = 11'({1'b0, r2_hman} << r2_hsh);
        if (r2_hexp == 5'd0) begin
            if (r2_hman == 10'd0) begin
                s2_half = {r2_sign, 31'd0};
            end else begin
                s2_half = {r2_sign, 8'(8'd113 - 8'(r2_hsh)), s2_norm[9:0], 13'd0};
            end
        end else if (r2_hexp == 5'h1F) begin
            s2_half = {r2_sign, 8'hFF, r2_hman, 13'd0};
        end else begin
            s2_half = {r2_sign, 8'(8'(r2_hexp) + 8'd112), r2_hman, 13'd0};
        end
        s2_bfrac = 23'({15'd0, r2_bmag} << (5'd23 - 5'(r2_bmsb)));
        if (r2_bmag == 8'd0) begin
            s2_byte = 32'd0;
        end else begin
            s2_byte = {r2_sign, 8'(8'd127 + 8'(r2_bmsb)), s2_bfrac};
        end
        s2_err = 1'b0;
        case (r2_fmt)
            esf_pkg::FMT_SINGLE: s2_res = r2_bits;
            esf_pkg::FMT_BF16:   s2_res = {r2_bits[15:0], 16'd0};
            esf_pkg::FMT_HALF:   s2_res = s2_half;
            esf_pkg::FMT_BYTE:   s2_res = s2_byte;
            default: begin
                s2_res = 32'd0;
                s2_err = 1'b1;
            end
        endcase
    end
    always_ff @(posedge i_clk) begin
        if (adv[2]) begin
            r3_out.float_bits   <= s2_res;
            r3_out.format_error <= s2_err;
            r3_out.last_out     <= r2_last;
        end
    end

    // A stalled result must hold its valid and content.
    `ESF_ASSERT_NXT(a_stall_hold, ctl3.stall, r_vld[NStage-1] && $stable(r3_out))
    // Error results carry zero data.
    `ESF_ASSERT_IMP(a_err_zero, ctl3.valid && r3_out.format_error, r3_out.float_bits == 32'd0)
    // Input is refused only when the whole pipe is full and stalled.
    `ESF_ASSERT_IMP(a_ready_full, !i_elem.ready, r_vld == '1 && ctl3.stall)
endmodule
`default_nettype wire

// ===== src/esf_lzc.sv =====
// Leading-one position of a 10-bit half mantissa, as a shift count.
// Depends on nothing outside itself.
`default_nettype none
module esf_lzc (
    input  wire logic [9:0] i_mant,
    output logic      [3:0] o_shift
);
    // Shift needed to bring the leading one to bit 10 (1 to 10).
    always_comb begin
        o_shift = 4'd10;
        for (int k = 0; k < 10; k++) begin
            if (i_mant[k]) begin
                o_shift = 4'(10 - k);
            end
        end
    end
endmodule
`default_nettype wire
